// ----- src/smpe_pkg.sv -----
// Package with the shared constants, types and helpers of the serial mouse packet encoder.
package smpe_pkg;

	localparam int CNT_BITS    = 12;
	localparam int DELTA_BITS  = CNT_BITS + 1;
	localparam int QUEUE_DEPTH = 256;
	localparam int QADDR_BITS  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QADDR_BITS + 1;

	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_LINES = 1'b1;

	localparam logic PROTO_MS   = 1'b0;
	localparam logic PROTO_MSYS = 1'b1;

	localparam logic [7:0] BYTE_IDENT = 8'h4D;
	localparam logic [7:0] MS_SYNC    = 8'h40;
	localparam logic [7:0] MSYS_SYNC  = 8'h80;

	typedef struct packed {
		logic accept;
		logic wr_ident;
		logic wr_pkt;
		logic pop;
		logic load_result;
	} smpe_cmd_t;

	typedef struct packed {
		logic plan_ident;
		logic plan_build;
		logic plan_scan;
		logic build_last;
		logic out_free;
	} smpe_sts_t;

	function automatic logic [7:0] clamp8(input logic signed [DELTA_BITS-1:0] v);
		logic [7:0] r;
		if (v < -128) begin
			r = 8'h80;
		end else if (v > 127) begin
			r = 8'h7F;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ----- src/smpe_ctrl.sv -----
// Controller state machine sequencing each word through the encoder datapath.
module smpe_ctrl
	import smpe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  smpe_sts_t sts,
	output smpe_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_BUILD,
		ST_READ,
		ST_RESULT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.accept      = (state_q == ST_IDLE) && in_valid;
		cmd.wr_ident    = (state_q == ST_DECIDE) && sts.plan_ident;
		cmd.wr_pkt      = (state_q == ST_BUILD);
		cmd.pop         = (state_q == ST_READ);
		cmd.load_result = (state_q == ST_RESULT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (sts.plan_ident) begin
						state_q <= ST_RESULT;
					end else if (sts.plan_build) begin
						state_q <= ST_BUILD;
					end else if (sts.plan_scan) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_BUILD: begin
					if (sts.build_last) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/smpe_datapath.sv -----
// Datapath of the encoder: deltas, packet bytes, byte queue, line status and result register.
module smpe_datapath
	import smpe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  smpe_cmd_t           cmd,
	output smpe_sts_t           sts,
	input  logic                opcode,
	input  logic [CNT_BITS-1:0] x_count,
	input  logic [CNT_BITS-1:0] y_count,
	input  logic [2:0]          buttons,
	input  logic                dtr,
	input  logic                rts,
	input  logic                cfg_we,
	input  logic                cfg_data,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                byte_valid,
	output logic [7:0]          byte_value,
	output logic                dsr,
	output logic                cts
);

	localparam logic [2:0] IDX_LAST_MS   = 3'd2;
	localparam logic [2:0] IDX_LAST_MSYS = 3'd4;

	logic                         protocol_q;
	logic [CNT_BITS-1:0]          prev_x_q;
	logic [CNT_BITS-1:0]          prev_y_q;
	logic [2:0]                   last_buttons_q;
	logic [1:0]                   line_q;
	logic                         scanning_q;
	logic signed [DELTA_BITS-1:0] dx_q;
	logic signed [DELTA_BITS-1:0] dy_q;
	logic [2:0]                   nb_q;
	logic [2:0]                   idx_q;
	logic                         plan_ident_q;
	logic                         plan_build_q;
	logic                         plan_scan_q;
	logic                         flag_q;
	logic [QADDR_BITS-1:0]        head_q;
	logic [QADDR_BITS-1:0]        tail_q;
	logic [QCNT_BITS-1:0]         count_q;
	logic [7:0]                   mem_q [QUEUE_DEPTH];
	logic [7:0]                   rdata_q;
	logic                         out_valid_q;
	logic                         byte_valid_q;
	logic [7:0]                   byte_value_q;
	logic                         dsr_q;
	logic                         cts_q;

	logic signed [DELTA_BITS-1:0] dx_new;
	logic signed [DELTA_BITS-1:0] dy_new;
	logic signed [DELTA_BITS-1:0] dx_rem;
	logic signed [DELTA_BITS-1:0] dy_rem;
	logic [7:0]                   ux;
	logic [7:0]                   uy;
	logic [7:0]                   pkt_byte;
	logic [7:0]                   wr_data;
	logic [2:0]                   idx_last;
	logic                         chunk_end;
	logic                         q_full;
	logic                         q_empty;
	logic                         mem_we;
	logic                         mem_re;
	logic [1:0]                   new_lines;

	always_comb begin
		dx_new = signed'({x_count[CNT_BITS-1], x_count}) - signed'({prev_x_q[CNT_BITS-1], prev_x_q});
		dy_new = signed'({y_count[CNT_BITS-1], y_count}) - signed'({prev_y_q[CNT_BITS-1], prev_y_q});
		ux     = clamp8(dx_q);
		uy     = clamp8(dy_q);
		dx_rem = dx_q - DELTA_BITS'(signed'(ux));
		dy_rem = dy_q - DELTA_BITS'(signed'(uy));
		idx_last  = (protocol_q == PROTO_MSYS) ? IDX_LAST_MSYS : IDX_LAST_MS;
		chunk_end = (idx_q == idx_last);
		new_lines = {rts, dtr};
	end

	always_comb begin
		pkt_byte = 8'h00;
		if (protocol_q == PROTO_MSYS) begin
			case (idx_q)
				3'd0:    pkt_byte = MSYS_SYNC | {5'b00000, nb_q};
				3'd1:    pkt_byte = ux;
				3'd2:    pkt_byte = uy;
				default: pkt_byte = 8'h00;
			endcase
		end else begin
			case (idx_q)
				3'd0:    pkt_byte = MS_SYNC | {2'b00, nb_q[1:0], uy[7:6], ux[7:6]};
				3'd1:    pkt_byte = {2'b00, ux[5:0]};
				3'd2:    pkt_byte = {2'b00, uy[5:0]};
				default: pkt_byte = 8'h00;
			endcase
		end
	end

	assign q_full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign mem_we  = (cmd.wr_ident || cmd.wr_pkt) && !q_full;
	assign mem_re  = cmd.pop && !q_empty;
	assign wr_data = cmd.wr_ident ? BYTE_IDENT : pkt_byte;

	always_comb begin
		sts            = '0;
		sts.plan_ident = plan_ident_q;
		sts.plan_build = plan_build_q;
		sts.plan_scan  = plan_scan_q;
		sts.build_last = chunk_end && (dx_rem == '0) && (dy_rem == '0);
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[head_q] <= wr_data;
		end
		if (mem_re) begin
			rdata_q <= mem_q[tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && opcode == OP_SCAN && scanning_q) begin
			dx_q <= dx_new;
			dy_q <= (protocol_q == PROTO_MSYS) ? -dy_new : dy_new;
			nb_q <= buttons;
		end else if (cmd.wr_pkt && chunk_end) begin
			dx_q <= dx_rem;
			dy_q <= dy_rem;
		end
		if (cmd.load_result) begin
			byte_valid_q <= flag_q;
			byte_value_q <= flag_q ? rdata_q : 8'h00;
			dsr_q        <= line_q[0];
			cts_q        <= line_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_q     <= PROTO_MS;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			last_buttons_q <= '0;
			line_q         <= 2'b11;
			scanning_q     <= 1'b0;
			idx_q          <= '0;
			plan_ident_q   <= 1'b0;
			plan_build_q   <= 1'b0;
			plan_scan_q    <= 1'b0;
			flag_q         <= 1'b0;
			head_q         <= '0;
			tail_q         <= '0;
			count_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				protocol_q <= cfg_data;
			end
			if (cmd.accept) begin
				plan_ident_q <= 1'b0;
				plan_build_q <= 1'b0;
				plan_scan_q  <= 1'b0;
				flag_q       <= 1'b0;
				idx_q        <= '0;
				if (opcode == OP_LINES) begin
					if (new_lines[1] != line_q[1]) begin
						head_q  <= '0;
						tail_q  <= '0;
						count_q <= '0;
						if (new_lines[1]) begin
							last_buttons_q <= '0;
							scanning_q     <= 1'b1;
							plan_ident_q   <= 1'b1;
						end else begin
							scanning_q <= 1'b0;
						end
					end
					line_q <= new_lines;
				end else if (scanning_q) begin
					prev_x_q       <= x_count;
					prev_y_q       <= y_count;
					last_buttons_q <= buttons;
					plan_scan_q    <= 1'b1;
					plan_build_q   <= q_empty && ((dx_new != '0) || (dy_new != '0) ||
						(buttons != last_buttons_q));
				end
			end
			if (cmd.wr_pkt) begin
				idx_q <= chunk_end ? 3'd0 : idx_q + 3'd1;
			end
			if (mem_we) begin
				head_q  <= head_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (mem_re) begin
				tail_q  <= tail_q + 1'b1;
				count_q <= count_q - 1'b1;
				flag_q  <= 1'b1;
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_valid = byte_valid_q;
	assign byte_value = byte_value_q;
	assign dsr        = dsr_q;
	assign cts        = cts_q;

endmodule

// ----- src/serial_mouse_packet_encoder.sv -----
// Top level of the serial mouse packet encoder: controller and datapath.
//
//   Channel  Signals                                        Direction
//   input    in_valid/in_ready, opcode, x_count, y_count,   host to block
//            buttons, dtr, rts
//   output   out_valid/out_ready, byte_valid, byte_value,   block to host
//            dsr, cts
//   config   cfg_we, cfg_data (protocol)                    host to block
//
// One word is worked on at a time. A handshake word passes through the decide and result
// states, the ident byte being written in the decide state. A scan tick passes through the
// decide, build (when a packet is due), read and result states, the build state writing
// one packet byte per cycle to the byte queue through the single write port of the queue.
// The finished result sits in an output register, which stalls the block only
// when a new result is ready and the previous one has not been taken.
// Reset is asynchronous and active low; the queue memory is not cleared.
module serial_mouse_packet_encoder
	import smpe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [CNT_BITS-1:0] x_count,
	input  logic [CNT_BITS-1:0] y_count,
	input  logic [2:0]          buttons,
	input  logic                dtr,
	input  logic                rts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                byte_valid,
	output logic [7:0]          byte_value,
	output logic                dsr,
	output logic                cts,
	input  logic                cfg_we,
	input  logic                cfg_data
);

	smpe_cmd_t cmd;
	smpe_sts_t sts;

	smpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smpe_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.x_count    (x_count),
		.y_count    (y_count),
		.buttons    (buttons),
		.dtr        (dtr),
		.rts        (rts),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.byte_valid (byte_valid),
		.byte_value (byte_value),
		.dsr        (dsr),
		.cts        (cts)
	);

endmodule
